// ===== src/svg_pkg.sv =====
`default_nettype none

package svg_pkg;

   // Gain fixed point format
   localparam int unsigned GAIN_FRAC_BITS = 27;
   localparam int unsigned GAIN_WIDTH     = 32;
   localparam int unsigned SAMPLE_WIDTH   = 32;
   localparam int unsigned SLEW_WIDTH     = 5;
   localparam int unsigned PRODUCT_WIDTH  = SAMPLE_WIDTH + GAIN_WIDTH;

   localparam logic signed [GAIN_WIDTH-1:0] GAIN_RESET_VALUE = 32'sd134217728;
   localparam logic [SLEW_WIDTH-1:0]        SLEW_RESET_VALUE = 5'd7;

   // Control register map
   localparam int unsigned CSR_INDEX_WIDTH = 2;
   localparam int unsigned CSR_DATA_WIDTH  = 32;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_REQUESTED_GAIN = 2'd0,
      CSR_MUTE           = 2'd1,
      CSR_GLIDE_SHIFT    = 2'd2
   } csr_index_type;

   // Register values seen by the slew stage
   typedef struct packed {
      logic signed [GAIN_WIDTH-1:0] requested_gain;
      logic                         mute;
      logic [SLEW_WIDTH-1:0]        glide_shift;
   } gain_cfg_type;

   // One queued transaction: sample plus the gain that applies to it
   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample;
      logic signed [GAIN_WIDTH-1:0]   gain;
   } work_type;

   // Queue between front and back
   localparam int unsigned QUEUE_DEPTH     = 2;
   localparam int unsigned QUEUE_PTR_WIDTH = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);

   // Push side handshake and pop side status
   typedef struct packed {
      logic push;
      logic full;
   } queue_push_type;

   typedef struct packed {
      logic pop;
      logic empty;
   } queue_pop_type;

endpackage

`default_nettype wire

// ===== src/svg_req_if.sv =====
`default_nettype none

interface svg_req_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [svg_pkg::SAMPLE_WIDTH-1:0]     sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

`default_nettype wire

// ===== src/svg_rsp_if.sv =====
`default_nettype none

interface svg_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic signed [svg_pkg::SAMPLE_WIDTH-1:0]     sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

`default_nettype wire

// ===== src/svg_front.sv =====
`default_nettype none

// Accepts samples and advances the gain one slew step per transaction.
module svg_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire svg_pkg::gain_cfg_type  cfg,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic signed [svg_pkg::SAMPLE_WIDTH-1:0] req_sample,
   input  wire logic                   queue_full,
   output logic                        queue_push,
   output svg_pkg::work_type           queue_data
);

   logic signed [svg_pkg::GAIN_WIDTH-1:0] gain_ff;
   logic signed [svg_pkg::GAIN_WIDTH-1:0] gain_in;
   logic signed [svg_pkg::GAIN_WIDTH:0]   target;
   logic signed [svg_pkg::GAIN_WIDTH:0]   diff;
   logic signed [svg_pkg::GAIN_WIDTH:0]   step;
   logic                                  accept;

   assign req_ready  = ~queue_full;
   assign accept     = req_valid & ~queue_full;
   assign queue_push = accept;

   // 33-bit difference never wraps; new gain lies between old and target
   always_comb begin
      target = cfg.mute ? '0 : {cfg.requested_gain[svg_pkg::GAIN_WIDTH-1], cfg.requested_gain};
      diff   = target - {gain_ff[svg_pkg::GAIN_WIDTH-1], gain_ff};
      step   = diff >>> cfg.glide_shift;
      gain_in = gain_ff + step[svg_pkg::GAIN_WIDTH-1:0];
   end

   assign queue_data.sample = req_sample;
   assign queue_data.gain   = gain_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff <= svg_pkg::GAIN_RESET_VALUE;
      end else if (accept) begin
         gain_ff <= gain_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/svg_queue.sv =====
`default_nettype none

// Small FIFO decoupling the slew stage from the multiply pipeline.
module svg_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire svg_pkg::work_type       push_data,
   output svg_pkg::queue_push_type      push_stat,
   input  wire logic                    pop,
   output svg_pkg::queue_pop_type       pop_stat,
   output svg_pkg::work_type            pop_data
);

   svg_pkg::work_type                      entry_ff [svg_pkg::QUEUE_DEPTH];
   logic [svg_pkg::QUEUE_PTR_WIDTH-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [svg_pkg::QUEUE_PTR_WIDTH-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [svg_pkg::QUEUE_CNT_WIDTH-1:0]    count_ff, count_in;
   logic                                   full;
   logic                                   empty;
   logic                                   do_push;
   logic                                   do_pop;

   assign full    = (count_ff == svg_pkg::QUEUE_CNT_WIDTH'(svg_pkg::QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;

   assign push_stat.push = do_push;
   assign push_stat.full = full;
   assign pop_stat.pop   = do_pop;
   assign pop_stat.empty = empty;
   assign pop_data       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == svg_pkg::QUEUE_PTR_WIDTH'(svg_pkg::QUEUE_DEPTH - 1))
                     ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == svg_pkg::QUEUE_PTR_WIDTH'(svg_pkg::QUEUE_DEPTH - 1))
                     ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/svg_back.sv =====
`default_nettype none

// Multiply, round, shift and saturate; two register stages.
module svg_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire svg_pkg::queue_pop_type  queue_stat,
   input  wire svg_pkg::work_type       queue_data,
   output logic                         queue_pop,
   output logic                         rsp_valid,
   input  wire logic                    rsp_ready,
   output logic signed [svg_pkg::SAMPLE_WIDTH-1:0] rsp_sample
);

   localparam int unsigned PW = svg_pkg::PRODUCT_WIDTH;
   localparam int unsigned SW = svg_pkg::SAMPLE_WIDTH;
   localparam logic signed [PW-1:0] ROUND_HALF = PW'(64'd1 << (svg_pkg::GAIN_FRAC_BITS - 1));
   localparam logic signed [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};

   logic signed [PW-1:0] product_ff, product_in;
   logic                 prod_valid_ff;
   logic signed [SW-1:0] out_ff, out_in;
   logic                 out_valid_ff;
   logic                 out_load;
   logic                 prod_load;
   logic signed [PW-1:0] rounded;
   logic signed [PW-1:0] shifted;
   logic [PW-SW:0]       high_bits;

   assign out_load  = prod_valid_ff & (~out_valid_ff | rsp_ready);
   assign prod_load = ~prod_valid_ff | out_load;
   assign queue_pop = prod_load & ~queue_stat.empty;

   assign product_in = $signed(queue_data.sample) * $signed(queue_data.gain);

   // |product| <= 2^62, so the rounding add stays inside 64 bits
   always_comb begin
      rounded   = product_ff + ROUND_HALF;
      shifted   = rounded >>> svg_pkg::GAIN_FRAC_BITS;
      high_bits = shifted[PW-1:SW-1];
      if (high_bits == '0 || high_bits == '1) begin
         out_in = shifted[SW-1:0];
      end else if (shifted[PW-1]) begin
         out_in = SAT_MIN;
      end else begin
         out_in = SAT_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (prod_load) begin
            prod_valid_ff <= queue_stat.pop;
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (queue_stat.pop) begin
         product_ff <= product_in;
      end
      if (out_load) begin
         out_ff <= out_in;
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign rsp_sample = out_ff;

endmodule

`default_nettype wire

// ===== src/slewed_volume_gain_unit.sv =====
`default_nettype none

// Channel   Dir  Handshake      Payload
// req       in   valid/ready    sample_in   (signed 32)
// rsp       out  valid/ready    sample_out  (signed 32)
// csr       in   csr_write_en   csr_index (2), csr_write_data (32)
//
// One transaction per cycle sustained while rsp is ready; an accepted req
// moves from slew into queue, multiply register, then output register.
// Throughput is set by the gain recurrence in the front stage.
// Reset (synchronous) restores gain 1.0 (Q4.27), unmuted, slew shift 7.
// A stalled rsp fills the output register, product stage and 2-deep queue
// before req_ready drops.
module slewed_volume_gain_unit (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   svg_req_if.sink                                     req,
   svg_rsp_if.source                                   rsp,
   input  wire logic                                   csr_write_en,
   input  wire logic [svg_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  wire logic [svg_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data
);

   // Control registers
   svg_pkg::gain_cfg_type cfg_ff;
   svg_pkg::gain_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (svg_pkg::csr_index_type'(csr_index))
            svg_pkg::CSR_REQUESTED_GAIN: begin
               cfg_in.requested_gain = csr_write_data[svg_pkg::GAIN_WIDTH-1:0];
            end
            svg_pkg::CSR_MUTE: begin
               cfg_in.mute = csr_write_data[0];
            end
            svg_pkg::CSR_GLIDE_SHIFT: begin
               cfg_in.glide_shift = csr_write_data[svg_pkg::SLEW_WIDTH-1:0];
            end
            default: begin
               // unmapped index: write dropped
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.requested_gain <= svg_pkg::GAIN_RESET_VALUE;
         cfg_ff.mute           <= 1'b0;
         cfg_ff.glide_shift    <= svg_pkg::SLEW_RESET_VALUE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front: accept transaction, slew gain, hand on to queue
   svg_pkg::queue_push_type push_stat;
   svg_pkg::queue_pop_type  pop_stat;
   svg_pkg::work_type       push_data;
   svg_pkg::work_type       pop_data;
   logic                    push;
   logic                    pop;

   svg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req.valid),
      .req_ready  (req.ready),
      .req_sample (req.sample_in),
      .queue_full (push_stat.full),
      .queue_push (push),
      .queue_data (push_data)
   );

   // Short queue so front and back stall independently
   svg_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .push_stat (push_stat),
      .pop       (pop),
      .pop_stat  (pop_stat),
      .pop_data  (pop_data)
   );

   // Back: multiply, round, saturate, output register
   svg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .queue_stat (pop_stat),
      .queue_data (pop_data),
      .queue_pop  (pop),
      .rsp_valid  (rsp.valid),
      .rsp_ready  (rsp.ready),
      .rsp_sample (rsp.sample_out)
   );

endmodule

`default_nettype wire

// ===== verif/svg_gain_checker.sv =====
`default_nettype none

module svg_gain_checker (
   input  wire logic                                clock,
   input  wire logic                                reset,
   svg_req_if                                       req,
   svg_rsp_if                                       rsp,
   input  wire logic                                csr_write_en,
   input  wire logic [svg_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [svg_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data,
   output int unsigned                              mismatch_count,
   output int unsigned                              outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   import svg_pkg::*;

   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_HIGH = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAT_LOW  = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   gain_cfg_type                     settings;
   logic signed [GAIN_WIDTH-1:0]     gain_now;
   logic signed [SAMPLE_WIDTH-1:0]   scaled_queue [$];

   // One slew step, difference held at 33 bits so it never wraps
   function automatic logic signed [GAIN_WIDTH-1:0] slewed_gain(
      input logic signed [GAIN_WIDTH-1:0] gain,
      input gain_cfg_type                 cfg
   );
      logic signed [GAIN_WIDTH:0] target;
      logic signed [GAIN_WIDTH:0] wide_gain;
      logic signed [GAIN_WIDTH:0] diff;
      logic signed [GAIN_WIDTH:0] step;
      target    = cfg.mute ? 33'sd0 : $signed(cfg.requested_gain);
      wide_gain = gain;
      diff      = target - wide_gain;
      step      = diff >>> cfg.glide_shift;
      return gain + step[GAIN_WIDTH-1:0];
   endfunction

   // Multiply, round by half an LSB, floor shift, saturate
   function automatic logic signed [SAMPLE_WIDTH-1:0] scaled_sample(
      input logic signed [SAMPLE_WIDTH-1:0] sample,
      input logic signed [GAIN_WIDTH-1:0]   gain
   );
      logic signed [PRODUCT_WIDTH:0] acc;
      acc = sample * gain;
      acc = acc + (1 <<< (GAIN_FRAC_BITS - 1));
      acc = acc >>> GAIN_FRAC_BITS;
      if (acc > SAT_HIGH)
         return SAT_HIGH;
      if (acc < SAT_LOW)
         return SAT_LOW;
      return acc[SAMPLE_WIDTH-1:0];
   endfunction

   always @(posedge clock) begin : watch
      logic signed [SAMPLE_WIDTH-1:0] wanted;
      if (reset) begin
         settings.requested_gain = GAIN_RESET_VALUE;
         settings.mute           = 1'b0;
         settings.glide_shift    = SLEW_RESET_VALUE;
         gain_now                = GAIN_RESET_VALUE;
         scaled_queue.delete();
         mismatch_count <= 0;
      end else begin
         if (req.valid && req.ready) begin
            gain_now = slewed_gain(gain_now, settings);
            scaled_queue.push_back(scaled_sample(req.sample_in, gain_now));
         end
         if (rsp.valid && rsp.ready) begin
            if (scaled_queue.size() == 0) begin
               $display("%0t: sample_out expected none, actual %0d", $time, rsp.sample_out);
               mismatch_count <= mismatch_count + 1;
            end else begin
               wanted = scaled_queue.pop_front();
               if (rsp.sample_out !== wanted) begin
                  $display("%0t: sample_out expected %0d, actual %0d",
                           $time, wanted, rsp.sample_out);
                  mismatch_count <= mismatch_count + 1;
               end
            end
         end
         // register writes land after any sample taken on the same edge
         if (csr_write_en) begin
            case (csr_index)
               CSR_REQUESTED_GAIN: settings.requested_gain = csr_write_data;
               CSR_MUTE:           settings.mute = csr_write_data[0];
               CSR_GLIDE_SHIFT:    settings.glide_shift = csr_write_data[SLEW_WIDTH-1:0];
               default:            ;
            endcase
         end
      end
      outstanding <= scaled_queue.size();
   end

endmodule

`default_nettype wire

// ===== verif/slewed_volume_gain_unit_test.sv =====
`default_nettype none

// Stimulus and verdict for the slewed volume gain unit. All prediction and
// comparison lives in svg_gain_checker; this module only drives the ports.
module slewed_volume_gain_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import svg_pkg::*;

   localparam logic [CSR_INDEX_WIDTH-1:0]       CSR_UNUSED = 2'd3;
   localparam logic signed [SAMPLE_WIDTH-1:0]   FULL_POS   = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0]   FULL_NEG   = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
   localparam logic signed [GAIN_WIDTH-1:0]     GAIN_ONE_HALF_UP = 32'sh0C00_0000; // 1.5
   localparam int unsigned                      RANDOM_ITEMS = 1900;

   logic                          clock;
   logic                          reset;
   logic                          csr_write_en;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index;
   logic [CSR_DATA_WIDTH-1:0]     csr_write_data;
   int unsigned                   mismatch_count;
   int unsigned                   outstanding;

   svg_req_if req_ch ();
   svg_rsp_if rsp_ch ();

   slewed_volume_gain_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data)
   );

   svg_gain_checker gain_check (
      .clock          (clock),
      .reset          (reset),
      .req            (req_ch),
      .rsp            (rsp_ch),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // 12 ns period
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // Idle length: mostly none or short, now and then long. A quiet stretch
   // runs flat out.
   function automatic int unsigned idle_len(input bit quiet);
      int unsigned pick;
      if (quiet)
         return 0;
      pick = $urandom_range(0, 99);
      if (pick < 50)
         return 0;
      if (pick < 85)
         return $urandom_range(1, 3);
      if (pick < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Samples weighted towards the rails and near zero, rest uniform
   function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
      case ($urandom_range(0, 9))
         0:       return FULL_POS;
         1:       return FULL_NEG;
         2:       return int'($urandom_range(0, 512)) - 256;
         3:       return int'($urandom_range(0, 2)) - 1;
         default: return $urandom();
      endcase
   endfunction

   // Gains: the extremes, zero, a spread around zero (+/-4.0), or anything
   function automatic logic signed [GAIN_WIDTH-1:0] random_gain();
      case ($urandom_range(0, 9))
         0:       return FULL_POS;
         1:       return FULL_NEG;
         2:       return '0;
         3, 4, 5: return int'($urandom_range(0, 32'h4000_0000)) - 32'sh2000_0000;
         default: return $urandom();
      endcase
   endfunction

   // Drop valid and let the pipe empty. The count from the checker is registered,
   // so always wait for a clock edge before looking at it.
   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do
         @(posedge clock);
      while (outstanding != 0);
   endtask

   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0]  value);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en   <= 1'b0;
      @(posedge clock);
   endtask

   // One transaction on req; valid stays up afterwards so back-to-back
   // samples never lower and raise it in the same step
   task automatic feed_sample(input logic signed [SAMPLE_WIDTH-1:0] value,
                              input int unsigned                    gap);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.sample_in <= value;
      do
         @(posedge clock);
      while (!req_ch.ready);
   endtask

   // A handful of writes in random order, junk above each field's width,
   // sometimes to the unused index
   task automatic reprogram();
      logic [CSR_INDEX_WIDTH-1:0] idx;
      logic [CSR_DATA_WIDTH-1:0]  value;
      repeat ($urandom_range(1, 4)) begin
         idx   = $urandom_range(0, 3);
         value = $urandom();
         case (idx)
            CSR_REQUESTED_GAIN: value = random_gain();
            CSR_MUTE:           value[0] = ($urandom_range(0, 9) < 3);
            CSR_GLIDE_SHIFT: begin
               case ($urandom_range(0, 6))
                  0:       value[SLEW_WIDTH-1:0] = '0;
                  1:       value[SLEW_WIDTH-1:0] = '1;
                  2, 3, 4: value[SLEW_WIDTH-1:0] = $urandom_range(1, 8);
                  default: ;
               endcase
            end
            default: ;
         endcase
         write_register(idx, value);
      end
   endtask

   // Result side: ready bursts, mostly short, with the odd long clean run,
   // separated by stalls of the same mix as the sender's gaps
   initial begin : drain_side
      int unsigned burst;
      int unsigned stall;
      rsp_ch.ready <= 1'b0;
      repeat (10) @(posedge clock);
      forever begin
         rsp_ch.ready <= 1'b1;
         burst = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 400)
                                             : $urandom_range(1, 20);
         repeat (burst) @(posedge clock);
         rsp_ch.ready <= 1'b0;
         stall = 1 + idle_len(1'b0);
         repeat (stall) @(posedge clock);
      end
   end

   initial begin : stimulus
      int unsigned fed;
      int unsigned phase_items;
      bit          quiet;
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.sample_in <= '0;
      csr_write_en     <= 1'b0;
      csr_index        <= '0;
      csr_write_data   <= '0;
      fed = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Values out of reset: unity gain already at target, slew 7
      feed_sample('0, 0);
      feed_sample(1, 0);
      feed_sample(-1, 0);
      feed_sample(FULL_POS, 0);
      feed_sample(FULL_NEG, 0);
      wait_for_drain();

      // Zero slew shift (junk above the field) jumps straight to the largest
      // gain; rail samples saturate both ways
      write_register(CSR_GLIDE_SHIFT, 32'hFFFF_FFE0);
      write_register(CSR_REQUESTED_GAIN, FULL_POS);
      feed_sample(FULL_POS, 0);
      feed_sample(FULL_NEG, 0);
      feed_sample(-1, 0);
      feed_sample(1, 0);
      wait_for_drain();

      // Full-span jump to the most negative gain
      write_register(CSR_REQUESTED_GAIN, FULL_NEG);
      feed_sample(FULL_POS, 0);
      feed_sample(FULL_NEG, 0);
      feed_sample(12345, 0);
      wait_for_drain();

      // Mute written as all ones, slowest slew, and a write to the unused
      // index that must change nothing
      write_register(CSR_UNUSED, $urandom());
      write_register(CSR_MUTE, 32'hFFFF_FFFF);
      write_register(CSR_GLIDE_SHIFT, 32'hFFFF_FFFF);
      feed_sample(FULL_POS, 0);
      feed_sample(FULL_NEG, 0);
      feed_sample(-7, 0);
      wait_for_drain();

      // New gain requested while muted; the gain keeps decaying towards zero
      write_register(CSR_GLIDE_SHIFT, 32'hFFFF_FFE1);
      write_register(CSR_REQUESTED_GAIN, GAIN_ONE_HALF_UP);
      feed_sample(FULL_POS, 0);
      feed_sample(32'sh1234_5678, 0);
      feed_sample(FULL_NEG, 0);
      wait_for_drain();

      // Unmute (bit 0 clear, junk above) with zero slew: the gain written
      // while muted applies at once
      write_register(CSR_MUTE, 32'hFFFF_FFFE);
      write_register(CSR_GLIDE_SHIFT, 32'h0000_0020);
      feed_sample(FULL_POS, 0);
      feed_sample(32'sh1234_5678, 0);
      feed_sample(-3, 0);

      // Random phases: each starts from an empty pipe, so the sender has
      // held off until every expected transaction has come back
      while (fed < RANDOM_ITEMS) begin
         wait_for_drain();
         reprogram();
         phase_items = $urandom_range(20, 160);
         quiet       = ($urandom_range(0, 4) == 0);
         repeat (phase_items)
            feed_sample(random_sample(), idle_len(quiet));
         fed += phase_items;
      end

      wait_for_drain();
      // wait on to catch anything stray from the three-stage pipe
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Backstop: far beyond the slowest legal run
   initial begin : watchdog
      #20ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

`default_nettype wire

// ===== slewed_volume_gain_unit.f =====
src/svg_pkg.sv
src/svg_req_if.sv
src/svg_rsp_if.sv
src/svg_front.sv
src/svg_queue.sv
src/svg_back.sv
src/slewed_volume_gain_unit.sv
verif/svg_gain_checker.sv
verif/slewed_volume_gain_unit_test.sv
